// ===== rtl/llpf_pkg.sv =====
// Shared types and constants of the laser line row peak finder.
// Used by every module of the block; depends on nothing.
package llpf_pkg;

	localparam int MAX_LINE_DEF = 4096;
	localparam int MAX_ROWS_DEF = 4096;
	localparam int QUEUE_DEPTH  = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int POS_W      = 12;
	localparam int PIX_W      = 8;

	localparam logic [12:0] LINE_WIDTH_RST = 13'd800;
	localparam logic [11:0] FIRST_ROW_RST  = 12'd200;
	localparam logic [12:0] END_ROW_RST    = 13'd550;
	localparam logic [11:0] FIRST_COL_RST  = 12'd50;
	localparam logic [12:0] END_COL_RST    = 13'd400;
	localparam logic [7:0]  MIN_PEAK_RST   = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH = 3'd0,
		CFG_FIRST_ROW  = 3'd1,
		CFG_END_ROW    = 3'd2,
		CFG_FIRST_COL  = 3'd3,
		CFG_END_COL    = 3'd4,
		CFG_MIN_PEAK   = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [12:0] line_width;
		logic [11:0] first_row;
		logic [12:0] end_row;
		logic [11:0] first_col;
		logic [12:0] end_col;
		logic [7:0]  min_peak;
	} llpf_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             in_win;
		logic             frame_start;
		logic             row_end;
		logic             emit;
		logic             last;
	} llpf_item_t;

endpackage

// ===== rtl/laser_line_row_peak_finder_top.sv =====
// Top level of the laser line row peak finder: configuration registers and wiring.
// Depends on llpf_pkg, llpf_front, llpf_queue and llpf_back.
//
// Usage: pixels enter in raster order on the in channel (pixel, frame_start),
// one request per cycle at most. frame_start marks column 0 of row 0. The block
// counts columns and rows itself; for every row inside the row window it sends
// one result (row_index, peak_col, peak_value, last_row) on the out channel at
// the last pixel of that row. The cfg channel writes register cfg_index with
// cfg_data and is always ready; write it only while no pixel is in flight.
// Throughput is one pixel per cycle while the receiver keeps up. A result is
// valid once the last pixel of its row has been written into the queue and
// the peak tracker has loaded the result register as it takes that pixel.
// A two-entry queue parts the pixel counter from the peak tracker, so the input
// keeps accepting while a result waits; when the receiver stalls, the queue
// fills and in_ready drops after at most two more pixels.
// Reset clears counters, running peak and queue, and loads the default window.
module laser_line_row_peak_finder_top #(
	parameter int MAX_LINE = llpf_pkg::MAX_LINE_DEF,
	parameter int MAX_ROWS = llpf_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] row_index,
	output logic [11:0] peak_col,
	output logic [7:0]  peak_value,
	output logic        last_row,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import llpf_pkg::*;

	llpf_cfg_t  cfg_q;
	llpf_item_t wr_item;
	llpf_item_t rd_item;
	logic       push;
	logic       pop;
	logic       full;
	logic       not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width <= LINE_WIDTH_RST;
			cfg_q.first_row  <= FIRST_ROW_RST;
			cfg_q.end_row    <= END_ROW_RST;
			cfg_q.first_col  <= FIRST_COL_RST;
			cfg_q.end_col    <= END_COL_RST;
			cfg_q.min_peak   <= MIN_PEAK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				CFG_FIRST_ROW:  cfg_q.first_row  <= cfg_data[11:0];
				CFG_END_ROW:    cfg_q.end_row    <= cfg_data;
				CFG_FIRST_COL:  cfg_q.first_col  <= cfg_data[11:0];
				CFG_END_COL:    cfg_q.end_col    <= cfg_data;
				CFG_MIN_PEAK:   cfg_q.min_peak   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	llpf_front #(
		.MAX_LINE(MAX_LINE),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.frame_start(frame_start),
		.push       (push),
		.item       (wr_item),
		.full       (full)
	);

	llpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.rd_item  (rd_item)
	);

	llpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.not_empty (not_empty),
		.item      (rd_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.peak_col  (peak_col),
		.peak_value(peak_value),
		.last_row  (last_row)
	);

endmodule

// ===== rtl/llpf_front.sv =====
// Front end: accepts pixel requests, counts column and row, and classifies each pixel.
// Depends on llpf_pkg; feeds llpf_queue.
module llpf_front #(
	parameter int MAX_LINE = llpf_pkg::MAX_LINE_DEF,
	parameter int MAX_ROWS = llpf_pkg::MAX_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llpf_pkg::llpf_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            pixel,
	input  logic                  frame_start,
	output logic                  push,
	output llpf_pkg::llpf_item_t  item,
	input  logic                  full
);
	import llpf_pkg::*;

	localparam int CW  = $clog2(MAX_LINE);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int XW  = (CW + 1 > 13) ? CW + 1 : 13;
	localparam int RXW = (RW + 1 > 13) ? RW + 1 : 13;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [XW-1:0]  width_c;
	logic [XW-1:0]  c_x;
	logic [XW-1:0]  c_inc;
	logic [RXW-1:0] r_x;
	logic [RXW-1:0] r_inc;
	logic           row_in;
	logic           col_in;
	logic           eol;

	always_comb begin
		if (cfg.line_width == '0) begin
			width_c = XW'(1);
		end else if (XW'(cfg.line_width) > XW'(MAX_LINE)) begin
			width_c = XW'(MAX_LINE);
		end else begin
			width_c = XW'(cfg.line_width);
		end
		c_x    = frame_start ? '0 : XW'(col_q);
		r_x    = frame_start ? '0 : RXW'(row_q);
		c_inc  = c_x + XW'(1);
		r_inc  = r_x + RXW'(1);
		row_in = (r_x >= RXW'(cfg.first_row)) && (r_x < RXW'(cfg.end_row));
		col_in = (c_x >= XW'(cfg.first_col)) && (c_x < XW'(cfg.end_col));
		eol    = c_inc >= width_c;
	end

	assign in_ready = !full;
	assign push     = in_valid && in_ready;

	always_comb begin
		item.pixel       = pixel;
		item.col         = POS_W'(c_x);
		item.row         = POS_W'(r_x);
		item.in_win      = row_in && col_in;
		item.frame_start = frame_start;
		item.row_end     = eol;
		item.emit        = eol && row_in;
		item.last        = r_inc == RXW'(cfg.end_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (eol) begin
				col_q <= '0;
				row_q <= (r_inc >= RXW'(MAX_ROWS)) ? '0 : RW'(r_inc);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= RW'(r_x);
			end
		end
	end

endmodule

// ===== rtl/llpf_queue.sv =====
// Short queue of classified pixels between front and back end.
// Depends on llpf_pkg for the item type and depth.
module llpf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  llpf_pkg::llpf_item_t  wr_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output llpf_pkg::llpf_item_t  rd_item
);
	import llpf_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	llpf_item_t    mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full      = count_q == NW'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign rd_item   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("Queue popped while empty.");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop)
		else $error("Queue pushed while full.");

endmodule

// ===== rtl/llpf_back.sv =====
// Back end: tracks the running row peak and holds the result register.
// Depends on llpf_pkg; takes items from llpf_queue.
module llpf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llpf_pkg::llpf_cfg_t   cfg,
	input  logic                  not_empty,
	input  llpf_pkg::llpf_item_t  item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [11:0]           row_index,
	output logic [11:0]           peak_col,
	output logic [7:0]            peak_value,
	output logic                  last_row
);
	import llpf_pkg::*;

	logic [PIX_W-1:0] best_val_q;
	logic [POS_W-1:0] best_col_q;
	logic [PIX_W-1:0] base_val;
	logic [POS_W-1:0] base_col;
	logic [PIX_W-1:0] new_val;
	logic [POS_W-1:0] new_col;
	logic             out_valid_q;
	logic [POS_W-1:0] row_index_q;
	logic [POS_W-1:0] peak_col_q;
	logic [PIX_W-1:0] peak_value_q;
	logic             last_row_q;

	assign pop = not_empty && (!out_valid_q || out_ready);

	always_comb begin
		base_val = item.frame_start ? '0 : best_val_q;
		base_col = item.frame_start ? '0 : best_col_q;
		if (item.in_win && (item.pixel > base_val)) begin
			new_val = item.pixel;
			new_col = item.col;
		end else begin
			new_val = base_val;
			new_col = base_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_val_q  <= '0;
			best_col_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				best_val_q <= item.row_end ? '0 : new_val;
				best_col_q <= item.row_end ? '0 : new_col;
			end
			if (pop && item.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.emit) begin
			row_index_q  <= item.row;
			peak_col_q   <= (new_val < cfg.min_peak) ? '0 : new_col;
			peak_value_q <= new_val;
			last_row_q   <= item.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_index_q;
	assign peak_col   = peak_col_q;
	assign peak_value = peak_value_q;
	assign last_row   = last_row_q;

	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!out_valid_q || out_ready))
		else $error("Item taken while the result register was blocked.");

	a_dark_col: assert property (@(posedge clk) disable iff (!arst_n)
		best_val_q == '0 |-> best_col_q == '0)
		else $error("Peak column set without a peak value.");

	a_result_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (peak_value_q == '0) |-> peak_col_q == '0)
		else $error("Dark row reported a nonzero peak column.");

endmodule

// ===== tb/tb_laser_line_row_peak_finder_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for laser_line_row_peak_finder_top: raster pixel requests in,
// per-row peak results checked against an in-bench row peak tracker.
// Depends on llpf_pkg and the block's RTL only.
module tb_laser_line_row_peak_finder_top;
	import llpf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0] pix;
		logic       fs;
	} pixel_req_t;

	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  val;
		logic        last;
	} row_peak_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  pixel = 8'd0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] row_index;
	logic [11:0] peak_col;
	logic [7:0]  peak_value;
	logic        last_row;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_LINE_WIDTH;
	logic [12:0] cfg_data = 13'd0;

	pixel_req_t  pending_pixels[$];
	row_peak_t   expected_peaks[$];
	int unsigned fail_count = 0;
	int unsigned cycles = 0;
	logic        quiet = 1'b0;
	logic        hold_req = 1'b0;
	logic        holding = 1'b0;

	logic [12:0] line_width_cfg = LINE_WIDTH_RST;
	logic [11:0] first_row_cfg = FIRST_ROW_RST;
	logic [12:0] end_row_cfg = END_ROW_RST;
	logic [11:0] first_col_cfg = FIRST_COL_RST;
	logic [12:0] end_col_cfg = END_COL_RST;
	logic [7:0]  min_peak_cfg = MIN_PEAK_RST;

	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [7:0]  best_val = 8'd0;
	logic [11:0] best_at = 12'd0;

	laser_line_row_peak_finder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_index(row_index),
		.peak_col(peak_col),
		.peak_value(peak_value),
		.last_row(last_row),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void track_pixel(logic [7:0] pix, logic fs);
		int unsigned width;
		int unsigned r;
		int unsigned c;
		logic        row_in;
		row_peak_t   rec;
		width = 32'(line_width_cfg);
		if (width == 0)
			width = 1;
		if (width > MAX_LINE_DEF)
			width = MAX_LINE_DEF;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
			best_val = 8'd0;
			best_at = 12'd0;
		end
		r = row_pos;
		c = col_pos;
		row_in = (r >= 32'(first_row_cfg)) && (r < 32'(end_row_cfg));
		if (row_in && c >= 32'(first_col_cfg) && c < 32'(end_col_cfg) && pix > best_val) begin
			best_val = pix;
			best_at = c[11:0];
		end
		if (c + 1 >= width) begin
			if (row_in) begin
				rec.row = r[11:0];
				rec.col = (best_val < min_peak_cfg) ? 12'd0 : best_at;
				rec.val = best_val;
				rec.last = (r + 1 == 32'(end_row_cfg));
				expected_peaks.insert(expected_peaks.size(), rec);
			end
			best_val = 8'd0;
			best_at = 12'd0;
			col_pos = 0;
			row_pos = (r + 1 >= MAX_ROWS_DEF) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic logic [7:0] draw_pixel();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(0, 15));
			2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: return 8'($urandom_range(180, 182));
		endcase
	endfunction

	task automatic queue_frames(int unsigned count, int unsigned frame_len,
			int unsigned noise_pct);
		pixel_req_t req;
		for (int unsigned k = 0; k < count; k++) begin
			req.fs = (k % frame_len == 0) || ($urandom_range(0, 99) < noise_pct);
			req.pix = draw_pixel();
			pending_pixels.insert(pending_pixels.size(), req);
		end
	endtask

	task automatic add_pixel(logic [7:0] pix, logic fs);
		pixel_req_t req;
		req.pix = pix;
		req.fs = fs;
		pending_pixels.insert(pending_pixels.size(), req);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_peaks.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(cfg_index_t idx, logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic program_window(logic [12:0] lw, logic [12:0] fr, logic [12:0] er,
			logic [12:0] fc, logic [12:0] ec, logic [12:0] mp);
		put_reg(CFG_LINE_WIDTH, lw);
		put_reg(CFG_FIRST_ROW, fr);
		put_reg(CFG_END_ROW, er);
		put_reg(CFG_FIRST_COL, fc);
		put_reg(CFG_END_COL, ec);
		put_reg(CFG_MIN_PEAK, mp);
		cfg_valid <= 1'b0;
		line_width_cfg = lw;
		first_row_cfg = fr[11:0];
		end_row_cfg = er;
		first_col_cfg = fc[11:0];
		end_col_cfg = ec;
		min_peak_cfg = mp[7:0];
	endtask

	always @(posedge clk) begin : drive
		pixel_req_t req;
		logic       taken;
		if (arst_n) begin
			taken = in_valid && in_ready;
			if (taken)
				track_pixel(pixel, frame_start);
			if (!in_valid || taken) begin
				if (pending_pixels.size() != 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
					req = pending_pixels.pop_front();
					in_valid <= 1'b1;
					pixel <= req.pix;
					frame_start <= req.fs;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		row_peak_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_peaks.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: row %0d col %0d value %0d last %0b",
							row_index, peak_col, peak_value, last_row);
					fail_count++;
				end else begin
					want = expected_peaks.pop_front();
					if (row_index !== want.row || peak_col !== want.col ||
							peak_value !== want.val || last_row !== want.last) begin
						if (fail_count < 10)
							$display("expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
								want.row, want.col, want.val, want.last,
								row_index, peak_col, peak_value, last_row);
						fail_count++;
					end
				end
			end
			out_ready <= !holding && (quiet || $urandom_range(0, 99) >= 27);
		end
	end

	// The receiver stalls on its own for a long stretch once asked to.
	initial begin
		wait (hold_req);
		@(posedge clk);
		holding <= 1'b1;
		repeat (300) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("laser_line_row_peak_finder_top: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0]  dir_pix[25];
		logic [12:0] lw;
		logic [12:0] fr;
		logic [12:0] er;
		logic [12:0] fc;
		logic [12:0] ec;
		logic [12:0] mp;
		int unsigned eff;
		dir_pix = '{8'd255, 8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd200, 8'd255, 8'd7,
			8'd50, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd9, 8'd3, 8'd4,
			8'd5, 8'd60, 8'd240, 8'd77};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_frames(10, 800, 2);
		wait_drained();

		// Ties, a weak row, a dark row, and a new frame inside an open row.
		program_window(13'd4, 13'd1, 13'd4, 13'd1, 13'd3, 13'd100);
		for (int k = 0; k < 25; k++)
			add_pixel(dir_pix[k], k == 0 || k == 18 || k == 24);
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			case ($urandom_range(0, 9))
				0: lw = 13'd0;
				1: lw = 13'd1;
				default: lw = 13'($urandom_range(2, 10));
			endcase
			fr = 13'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0: er = fr;
				1: er = 13'h1FFF;
				default: er = fr + 13'($urandom_range(1, 4));
			endcase
			fc = ($urandom_range(0, 19) == 0) ? 13'd4095 : 13'($urandom_range(0, 10));
			case ($urandom_range(0, 5))
				0: ec = fc;
				1: ec = 13'h1FFF;
				default: ec = fc + 13'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 5))
				0: mp = 13'd0;
				1: mp = 13'd255;
				default: mp = 13'($urandom_range(0, 8191));
			endcase
			if (p == 5) begin
				lw = 13'd2;
				fr = 13'd0;
				er = 13'h1FFF;
			end
			program_window(lw, fr, er, fc, ec, mp);
			eff = (lw == 13'd0) ? 1 : 32'(lw);
			if (p == 2)
				quiet = 1'b1;
			if (p == 5) begin
				quiet = 1'b1;
				hold_req = 1'b1;
				wait (holding);
			end
			queue_frames(50, eff * $urandom_range(2, 6), 2);
			wait_drained();
			quiet = 1'b0;
		end

		if (fail_count == 0)
			$display("laser_line_row_peak_finder_top: match");
		else
			$display("laser_line_row_peak_finder_top: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/llpf_pkg.sv
rtl/llpf_front.sv
rtl/llpf_queue.sv
rtl/llpf_back.sv
rtl/laser_line_row_peak_finder_top.sv
tb/tb_laser_line_row_peak_finder_top.sv
